// ===== hw/rtl/x86_16_instruction_field_decoder_assert.svh =====
// Assertion macros shared by the x86 field decoder RTL.
`ifndef X86_16_INSTRUCTION_FIELD_DECODER_ASSERT_SVH
`define X86_16_INSTRUCTION_FIELD_DECODER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define XFD_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define XFD_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/xfd_pkg.sv =====
// Types, opcode patterns and helpers for the x86 instruction field decoder.
package xfd_pkg;

   localparam int NUM_BYTES = 6;

   typedef logic [NUM_BYTES-1:0][7:0] window_type;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_TRUNC   = 2'd2;

   // instruction forms
   localparam logic [3:0] CL_MOV_RM_REG  = 4'd0;
   localparam logic [3:0] CL_MOV_IMM_RM  = 4'd1;
   localparam logic [3:0] CL_MOV_IMM_REG = 4'd2;
   localparam logic [3:0] CL_MOV_ACC_MEM = 4'd3;
   localparam logic [3:0] CL_MOV_SEG     = 4'd4;
   localparam logic [3:0] CL_ADD_RM_REG  = 4'd5;
   localparam logic [3:0] CL_ADD_IMM_RM  = 4'd6;
   localparam logic [3:0] CL_ADD_IMM_ACC = 4'd7;
   localparam logic [3:0] CL_SUB_RM_REG  = 4'd8;
   localparam logic [3:0] CL_SUB_IMM_RM  = 4'd9;
   localparam logic [3:0] CL_SUB_IMM_ACC = 4'd10;
   localparam logic [3:0] CL_CMP_RM_REG  = 4'd11;
   localparam logic [3:0] CL_CMP_IMM_RM  = 4'd12;
   localparam logic [3:0] CL_CMP_IMM_ACC = 4'd13;
   localparam logic [3:0] CL_JCC         = 4'd14;
   localparam logic [3:0] CL_LOOP        = 4'd15;

   // operand layouts
   localparam logic [2:0] KIND_REG_MEM  = 3'd0;
   localparam logic [2:0] KIND_IMM_RM   = 3'd1;
   localparam logic [2:0] KIND_IMM_REG  = 3'd2;
   localparam logic [2:0] KIND_ACC_MEM  = 3'd3;
   localparam logic [2:0] KIND_SEG      = 3'd4;
   localparam logic [2:0] KIND_IMM_ACC  = 3'd5;
   localparam logic [2:0] KIND_JUMP     = 3'd6;

   // group 80-83 opcode extensions
   localparam logic [2:0] EXT_ADD = 3'd0;
   localparam logic [2:0] EXT_SUB = 3'd5;
   localparam logic [2:0] EXT_CMP = 3'd7;

   // opcode patterns
   localparam logic [5:0] OPC_MOV_RM_REG  = 6'b100010;
   localparam logic [6:0] OPC_MOV_IMM_RM  = 7'b1100011;
   localparam logic [3:0] OPC_MOV_IMM_REG = 4'b1011;
   localparam logic [6:0] OPC_MOV_ACC_MEM = 7'b1010000;
   localparam logic [7:0] OPC_MOV_TO_SEG  = 8'b10001110;
   localparam logic [7:0] OPC_MOV_FROM_SEG = 8'b10001100;
   localparam logic [5:0] OPC_ADD_RM_REG  = 6'b000000;
   localparam logic [5:0] OPC_GRP_IMM     = 6'b100000;
   localparam logic [6:0] OPC_ADD_IMM_ACC = 7'b0000010;
   localparam logic [5:0] OPC_SUB_RM_REG  = 6'b001010;
   localparam logic [6:0] OPC_SUB_IMM_ACC = 7'b0010110;
   localparam logic [5:0] OPC_CMP_RM_REG  = 6'b001110;
   localparam logic [6:0] OPC_CMP_IMM_ACC = 7'b0011110;
   localparam logic [3:0] OPC_JCC         = 4'b0111;
   localparam logic [5:0] OPC_LOOP        = 6'b111000;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  op_class;
      logic        dir_bit;
      logic        wide_bit;
      logic [1:0]  mod_field;
      logic [2:0]  reg_field;
      logic [2:0]  rm_field;
      logic [15:0] disp_value;
      logic [1:0]  disp_bytes;
      logic [15:0] imm_value;
      logic [1:0]  imm_bytes;
      logic [2:0]  length;
   } decode_result_type;

   // little-endian fetch of n (0..2) bytes at pos; zero past the window
   function automatic logic [15:0] fetch(input window_type b, input logic [2:0] pos,
                                         input logic [1:0] n);
      logic [15:0] val;
      val = '0;
      if (n != 2'd0 && pos <= 3'd5) begin
         if (n == 2'd1 || pos == 3'd5) begin
            val = {8'h00, b[pos]};
         end else begin
            val = {b[3'(pos + 3'd1)], b[pos]};
         end
      end
      return val;
   endfunction

endpackage

// ===== hw/rtl/xfd_decode.sv =====
// Combinational decode of one instruction window into its fields.
module xfd_decode
   import xfd_pkg::*;
(
   input  window_type        win,
   input  logic [2:0]        left,
   output decode_result_type res
);

   logic [7:0]  op;
   logic [7:0]  b1;
   logic [1:0]  err;
   logic [3:0]  cls;
   logic [2:0]  kind;
   logic        d;
   logic        w;
   logic        s;
   logic [1:0]  md;
   logic [2:0]  rg;
   logic [2:0]  rm;
   logic [1:0]  nd;
   logic [1:0]  ni;
   logic [2:0]  len;
   logic [15:0] disp;
   logic [15:0] imm;

   assign op = win[0];
   assign b1 = win[1];

   always_comb begin
      err  = ST_OK;
      cls  = CL_MOV_RM_REG;
      kind = KIND_REG_MEM;
      d    = 1'b0;
      w    = op[0];
      s    = 1'b0;
      md   = 2'd0;
      rg   = 3'd0;
      rm   = 3'd0;
      nd   = 2'd0;
      ni   = 2'd0;
      len  = 3'd0;
      disp = '0;
      imm  = '0;

      priority if (op[7:2] == OPC_MOV_RM_REG) begin
         cls = CL_MOV_RM_REG;  kind = KIND_REG_MEM;
      end else if (op[7:1] == OPC_MOV_IMM_RM) begin
         cls = CL_MOV_IMM_RM;  kind = KIND_IMM_RM;
      end else if (op[7:4] == OPC_MOV_IMM_REG) begin
         cls = CL_MOV_IMM_REG; kind = KIND_IMM_REG;
      end else if (op[7:2] == OPC_MOV_ACC_MEM[6:1]) begin
         cls = CL_MOV_ACC_MEM; kind = KIND_ACC_MEM;
      end else if (op == OPC_MOV_TO_SEG || op == OPC_MOV_FROM_SEG) begin
         cls = CL_MOV_SEG;     kind = KIND_SEG;
      end else if (op[7:2] == OPC_ADD_RM_REG) begin
         cls = CL_ADD_RM_REG;  kind = KIND_REG_MEM;
      end else if (op[7:2] == OPC_GRP_IMM) begin
         kind = KIND_IMM_RM;
         // extension lives in the ModRM byte, so it needs a second byte
         if (left < 3'd2) begin
            err = ST_TRUNC;
         end else if (b1[5:3] == EXT_ADD) begin
            cls = CL_ADD_IMM_RM;
         end else if (b1[5:3] == EXT_SUB) begin
            cls = CL_SUB_IMM_RM;
         end else if (b1[5:3] == EXT_CMP) begin
            cls = CL_CMP_IMM_RM;
         end else begin
            err = ST_UNKNOWN;
         end
      end else if (op[7:1] == OPC_ADD_IMM_ACC) begin
         cls = CL_ADD_IMM_ACC; kind = KIND_IMM_ACC;
      end else if (op[7:2] == OPC_SUB_RM_REG) begin
         cls = CL_SUB_RM_REG;  kind = KIND_REG_MEM;
      end else if (op[7:1] == OPC_SUB_IMM_ACC) begin
         cls = CL_SUB_IMM_ACC; kind = KIND_IMM_ACC;
      end else if (op[7:2] == OPC_CMP_RM_REG) begin
         cls = CL_CMP_RM_REG;  kind = KIND_REG_MEM;
      end else if (op[7:1] == OPC_CMP_IMM_ACC) begin
         cls = CL_CMP_IMM_ACC; kind = KIND_IMM_ACC;
      end else if (op[7:4] == OPC_JCC) begin
         cls = CL_JCC;         kind = KIND_JUMP;
      end else if (op[7:2] == OPC_LOOP) begin
         cls = CL_LOOP;        kind = KIND_JUMP;
      end else begin
         err = ST_UNKNOWN;
      end

      if (kind == KIND_REG_MEM || kind == KIND_IMM_RM || kind == KIND_SEG) begin
         md = b1[7:6];
         rg = b1[5:3];
         rm = b1[2:0];
         if (md == 2'd1) begin
            nd = 2'd1;
         end else if (md == 2'd2) begin
            nd = 2'd2;
         end else if (md == 2'd0 && rm == 3'd6) begin
            nd = 2'd2;   // direct address
         end
         disp = fetch(win, 3'd2, nd);
         len  = 3'd2 + {1'b0, nd};
      end

      unique case (kind)
         KIND_REG_MEM: begin
            d = op[1];
         end
         KIND_SEG: begin
            d  = op[1];
            w  = 1'b1;
            rg = {1'b0, b1[4:3]};
         end
         KIND_IMM_RM: begin
            s   = (cls == CL_MOV_IMM_RM) ? 1'b0 : op[1];
            ni  = (w && !s) ? 2'd2 : 2'd1;
            imm = fetch(win, 3'd2 + {1'b0, nd}, ni);
            len = len + {1'b0, ni};
         end
         KIND_IMM_REG: begin
            w   = op[3];
            rg  = op[2:0];
            ni  = w ? 2'd2 : 2'd1;
            imm = fetch(win, 3'd1, ni);
            len = 3'd1 + {1'b0, ni};
         end
         KIND_ACC_MEM: begin
            d    = ~op[1];
            nd   = 2'd2;
            disp = fetch(win, 3'd1, 2'd2);
            len  = 3'd3;
         end
         KIND_IMM_ACC: begin
            d   = 1'b1;
            ni  = w ? 2'd2 : 2'd1;
            imm = fetch(win, 3'd1, ni);
            len = 3'd1 + {1'b0, ni};
         end
         default: begin
            w   = 1'b0;
            ni  = 2'd1;
            imm = {8'h00, b1};
            len = 3'd2;
         end
      endcase

      if (left == 3'd0) begin
         err = ST_TRUNC;
      end else if (err == ST_OK && len > left) begin
         err = ST_TRUNC;
      end

      res = '0;
      res.status = err;
      if (err == ST_OK) begin
         res.op_class   = cls;
         res.dir_bit    = d;
         res.wide_bit   = w;
         res.mod_field  = md;
         res.reg_field  = rg;
         res.rm_field   = rm;
         res.disp_value = disp;
         res.disp_bytes = nd;
         res.imm_value  = imm;
         res.imm_bytes  = ni;
         res.length     = len;
      end
   end

endmodule

// ===== hw/rtl/x86_16_instruction_field_decoder.sv =====
// Top level of the x86 instruction field decoder: input register, decode, result register.
//
//   channel   ports                        transfer
//   request   start, busy, req_*           start high and busy low at a rising edge
//   response  rsp_valid, rsp_*             rsp_valid high for one cycle, always taken
//
// One window is taken every cycle; busy never rises.
// The window is registered, decoded in one pass of logic, and the fields are
// registered together with the rsp_valid strobe.
// Synchronous reset clears the two valid flags; payload registers are not reset.
// The receiver cannot stall, so no result is ever held back.
`include "x86_16_instruction_field_decoder_assert.svh"

module x86_16_instruction_field_decoder
   import xfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_byte_zero,
   input  logic [7:0]  req_byte_one,
   input  logic [7:0]  req_byte_two,
   input  logic [7:0]  req_byte_three,
   input  logic [7:0]  req_byte_four,
   input  logic [7:0]  req_byte_five,
   input  logic [2:0]  req_bytes_left,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_op_class,
   output logic        rsp_dir_bit,
   output logic        rsp_wide_bit,
   output logic [1:0]  rsp_mod_field,
   output logic [2:0]  rsp_reg_field,
   output logic [2:0]  rsp_rm_field,
   output logic [15:0] rsp_disp_value,
   output logic [1:0]  rsp_disp_bytes,
   output logic [15:0] rsp_imm_value,
   output logic [1:0]  rsp_imm_bytes,
   output logic [2:0]  rsp_length
);

   logic              accept;
   window_type        win_ff;
   window_type        win_in;
   logic [2:0]        left_ff;
   logic              valid_ff;
   logic              valid_in;
   decode_result_type dec;
   decode_result_type res_ff;
   logic              rsp_valid_ff;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign valid_in = accept;
   assign win_in   = {req_byte_five, req_byte_four, req_byte_three,
                      req_byte_two, req_byte_one, req_byte_zero};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff  <= win_in;
         left_ff <= req_bytes_left;
      end
      if (valid_ff) begin
         res_ff <= dec;
      end
   end

   xfd_decode u_decode (
      .win  (win_ff),
      .left (left_ff),
      .res  (dec)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = res_ff.status;
   assign rsp_op_class   = res_ff.op_class;
   assign rsp_dir_bit    = res_ff.dir_bit;
   assign rsp_wide_bit   = res_ff.wide_bit;
   assign rsp_mod_field  = res_ff.mod_field;
   assign rsp_reg_field  = res_ff.reg_field;
   assign rsp_rm_field   = res_ff.rm_field;
   assign rsp_disp_value = res_ff.disp_value;
   assign rsp_disp_bytes = res_ff.disp_bytes;
   assign rsp_imm_value  = res_ff.imm_value;
   assign rsp_imm_bytes  = res_ff.imm_bytes;
   assign rsp_length     = res_ff.length;

   `XFD_CHECK(a_rsp_follows_req, clock, reset, rsp_valid |-> $past(accept, 2), "response without request")
   `XFD_CHECK(a_req_gives_rsp, clock, reset, valid_ff |=> rsp_valid, "request dropped in pipeline")
   `XFD_CHECK(a_err_clears_fields, clock, reset, (rsp_valid && rsp_status != ST_OK) |-> (rsp_length == 3'd0 && rsp_op_class == 4'd0 && rsp_imm_bytes == 2'd0), "error result carries fields")
   `XFD_CHECK(a_len_within_left, clock, reset, (rsp_valid && rsp_status == ST_OK) |-> (rsp_length != 3'd0 && rsp_length <= $past(left_ff)), "length exceeds bytes left")
   `XFD_NEVER(a_byte_counts, clock, reset, rsp_valid && (rsp_disp_bytes == 2'd3 || rsp_imm_bytes == 2'd3), "byte count out of range")

endmodule
